// ----- hw/rtl/spae_pkg.sv -----
// ============================================================================
// spae_pkg
// Shared constants, arcsine table and link types of the angle estimator.
// ============================================================================
package spae_pkg;

    localparam int HALF_WINDOW = 10;
    localparam int LINE_DEPTH  = 2 * HALF_WINDOW;
    localparam int ANGLE_BITS  = 16;

    localparam int SAMPLE_W    = 16;
    localparam int INV_W       = 24;
    localparam int X_W         = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int P1_W        = MAG_W + INV_W;
    localparam int K_W         = 16;
    localparam int SPLIT       = 20;
    localparam int PH_W        = P1_W - SPLIT + K_W;
    localparam int PL_W        = SPLIT + K_W;
    localparam int FULL_W      = P1_W + K_W + 1;
    localparam int Q_SHIFT     = 26;
    localparam int Q_W         = FULL_W - Q_SHIFT;

    localparam logic [K_W-1:0] INV_SQRT2_Q16 = 16'd46341;

    localparam logic signed [X_W-1:0] X_MAX   = {1'b0, {(X_W-1){1'b1}}};
    localparam logic signed [X_W-1:0] X_MIN   = {1'b1, {(X_W-1){1'b0}}};
    localparam logic signed [X_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [X_W-1:0] NEG_ONE_Q14 = -16'sd16384;

    localparam int SUM_W       = 17 + $clog2(HALF_WINDOW);
    localparam int D_W         = SUM_W + 1;

    localparam int TAB_W       = 15;
    localparam int TAB_N       = 17;
    localparam int TAB_FRAC    = 16;
    localparam int TIDX_W      = 5;
    localparam int IDX_W       = 4;
    localparam int FRAC_W      = 10;
    localparam int M_W         = IDX_W + FRAC_W;
    localparam int PROD_W      = TAB_W + FRAC_W;
    localparam int V_W         = TAB_W + 1;
    localparam int VS_W        = V_W + ANGLE_BITS + 1;

    localparam logic [TAB_W-1:0] ASIN_TAB [TAB_N] = '{
        15'd0,    15'd652,  15'd1307, 15'd1967, 15'd2636, 15'd3315,
        15'd4009, 15'd4723, 15'd5461, 15'd6231, 15'd7042, 15'd7907,
        15'd8846, 15'd9892, 15'd11113, 15'd12677, 15'd16384
    };

    localparam int ANG_W       = ANGLE_BITS;
    localparam int A_W         = ANG_W + 1;
    localparam int ANGLE_OUT_W = 16;

    localparam logic [A_W-1:0] FULL_TURN    = A_W'(1) << ANGLE_BITS;
    localparam logic [A_W-1:0] HALF_TURN    = A_W'(1) << (ANGLE_BITS - 1);
    localparam logic [A_W-1:0] QUARTER_TURN = A_W'(1) << (ANGLE_BITS - 2);
    localparam logic [A_W-1:0] THREE_QUARTER_TURN = A_W'(QUARTER_TURN * 3);
    localparam logic [ANG_W-1:0] ANGLE_MAX  = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic                  valid;
        logic signed [X_W-1:0] x;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hw/rtl/spae_front.sv -----
// ============================================================================
// spae_front
// Input side: take a beat, scale the sample to per-unit Q2.14, saturate.
// ============================================================================
module spae_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic signed [spae_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [spae_pkg::INV_W-1:0]        i_inverse_rms,
    input  spae_pkg::t_q_stat                 i_q_stat,
    output spae_pkg::t_q_push                 o_q_push
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_PART = 4'b0100,
        F_PUSH = 4'b1000
    } t_front_state;

    t_front_state r_state, n_state;

    logic [spae_pkg::MAG_W-1:0]  r_mag;
    logic [spae_pkg::INV_W-1:0]  r_inv;
    logic                        r_neg;
    logic [spae_pkg::P1_W-1:0]   r_p1;
    logic [spae_pkg::PH_W-1:0]   r_ph;
    logic [spae_pkg::PL_W-1:0]   r_pl;

    logic [spae_pkg::MAG_W-1:0]  s_ext;
    logic [spae_pkg::MAG_W-1:0]  mag_in;
    logic [spae_pkg::FULL_W-1:0] full_sum;
    logic [spae_pkg::Q_W-1:0]    q;
    logic signed [spae_pkg::X_W-1:0] x_sat;

    assign o_s_tready = (r_state == F_IDLE);

    assign s_ext  = {i_sample[spae_pkg::SAMPLE_W-1], i_sample};
    assign mag_in = i_sample[spae_pkg::SAMPLE_W-1] ? (~s_ext + spae_pkg::MAG_W'(1)) : s_ext;

    assign full_sum = spae_pkg::FULL_W'({r_ph, {spae_pkg::SPLIT{1'b0}}})
                    + spae_pkg::FULL_W'(r_pl)
                    + (spae_pkg::FULL_W'(1) << (spae_pkg::Q_SHIFT - 1));
    assign q = full_sum[spae_pkg::FULL_W-1:spae_pkg::Q_SHIFT];

    always_comb begin
        if (r_neg) begin
            if (q >= spae_pkg::Q_W'(32768)) begin
                x_sat = spae_pkg::X_MIN;
            end else begin
                x_sat = $signed(~q[spae_pkg::X_W-1:0] + spae_pkg::X_W'(1));
            end
        end else begin
            if (q > spae_pkg::Q_W'(32767)) begin
                x_sat = spae_pkg::X_MAX;
            end else begin
                x_sat = $signed(q[spae_pkg::X_W-1:0]);
            end
        end
    end

    assign o_q_push.valid = (r_state == F_PUSH);
    assign o_q_push.x     = x_sat;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_s_tvalid) n_state = F_MUL;
            F_MUL:   n_state = F_PART;
            F_PART:  n_state = F_PUSH;
            F_PUSH:  if (!i_q_stat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_s_tvalid) begin
            r_mag <= mag_in;
            r_inv <= i_inverse_rms;
            r_neg <= i_sample[spae_pkg::SAMPLE_W-1];
        end
        if (r_state == F_MUL) begin
            r_p1 <= r_mag * r_inv;
        end
        if (r_state == F_PART) begin
            r_ph <= r_p1[spae_pkg::P1_W-1:spae_pkg::SPLIT] * spae_pkg::INV_SQRT2_Q16;
            r_pl <= r_p1[spae_pkg::SPLIT-1:0] * spae_pkg::INV_SQRT2_Q16;
        end
    end

endmodule

// ----- hw/rtl/spae_queue.sv -----
// ============================================================================
// spae_queue
// Short queue of scaled samples between the front and back sections.
// ============================================================================
module spae_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spae_pkg::t_q_push             i_push,
    input  logic                          i_pop,
    output spae_pkg::t_q_stat             o_stat,
    output logic signed [spae_pkg::X_W-1:0] o_x
);

    logic signed [spae_pkg::X_W-1:0] r_mem [spae_pkg::QUEUE_DEPTH];
    logic [spae_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [spae_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [spae_pkg::QCNT_W-1:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == spae_pkg::QCNT_W'(spae_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_x          = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + spae_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + spae_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + spae_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - spae_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.x;
        end
    end

endmodule

// ----- hw/rtl/spae_back.sv -----
// ============================================================================
// spae_back
// Output side: slope window, arcsine lookup, quadrant and anti-fall logic.
// ============================================================================
module spae_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spae_pkg::t_q_stat                   i_q_stat,
    input  logic signed [spae_pkg::X_W-1:0]     i_x,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [spae_pkg::ANGLE_OUT_W-1:0]    o_angle,
    output logic                                o_held
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_SUM  = 4'b0010,
        B_ASIN = 4'b0100,
        B_ANG  = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;

    logic signed [spae_pkg::X_W-1:0]   r_line [spae_pkg::LINE_DEPTH];
    logic signed [spae_pkg::SUM_W-1:0] r_older;
    logic signed [spae_pkg::SUM_W-1:0] r_newer;
    logic [spae_pkg::ANG_W-1:0]        r_last;
    logic                              r_out_valid;

    logic signed [spae_pkg::X_W-1:0]   r_x;
    logic [spae_pkg::TAB_W-1:0]        r_base;
    logic [spae_pkg::TAB_W-1:0]        r_diff;
    logic [spae_pkg::FRAC_W-1:0]       r_frac;
    logic [spae_pkg::PROD_W-1:0]       r_prod;
    logic                              r_dpos;
    logic [spae_pkg::ANG_W-1:0]        r_angle;
    logic                              r_held;

    logic signed [spae_pkg::X_W-1:0]   leaving;
    logic signed [spae_pkg::X_W-1:0]   crossing;
    logic [spae_pkg::X_W-1:0]          x_abs;
    logic [spae_pkg::M_W-1:0]          m;
    logic [spae_pkg::IDX_W-1:0]        idx;
    logic [spae_pkg::TIDX_W-1:0]       idx_next;
    logic signed [spae_pkg::D_W-1:0]   d;
    logic [spae_pkg::V_W-1:0]          v;
    logic [spae_pkg::VS_W-1:0]         s_wide;
    logic [spae_pkg::ANG_W-1:0]        s;
    logic [spae_pkg::A_W-1:0]          a;
    logic [spae_pkg::ANG_W-1:0]        a_sat;
    logic [spae_pkg::ANG_W-1:0]        back_step;
    logic                              hold;
    logic                              load_out;
    logic                              x_neg;
    logic                              x_zero;

    assign leaving  = r_line[0];
    assign crossing = r_line[spae_pkg::HALF_WINDOW];

    assign x_abs    = r_x[spae_pkg::X_W-1] ? (~r_x + spae_pkg::X_W'(1)) : r_x;
    assign m        = x_abs[spae_pkg::M_W-1:0];
    assign idx      = m[spae_pkg::M_W-1:spae_pkg::FRAC_W];
    assign idx_next = spae_pkg::TIDX_W'(idx) + spae_pkg::TIDX_W'(1);

    assign d = spae_pkg::D_W'(r_newer) - spae_pkg::D_W'(r_older);

    assign x_neg  = r_x[spae_pkg::X_W-1];
    assign x_zero = (r_x == '0);

    assign v = spae_pkg::V_W'(r_base)
             + spae_pkg::V_W'((r_prod + spae_pkg::PROD_W'(1 << (spae_pkg::FRAC_W - 1)))
                              >> spae_pkg::FRAC_W);
    assign s_wide = (spae_pkg::VS_W'(v) << spae_pkg::ANGLE_BITS)
                  + (spae_pkg::VS_W'(1) << (spae_pkg::TAB_FRAC - 1));
    assign s = spae_pkg::ANG_W'(s_wide >> spae_pkg::TAB_FRAC);

    always_comb begin
        if (r_x >= spae_pkg::ONE_Q14) begin
            a = spae_pkg::QUARTER_TURN;
        end else if (r_x <= spae_pkg::NEG_ONE_Q14) begin
            a = spae_pkg::THREE_QUARTER_TURN;
        end else if (!x_neg && !x_zero && r_dpos) begin
            a = spae_pkg::A_W'(s);
        end else if (!r_dpos) begin
            a = x_neg ? (spae_pkg::HALF_TURN + spae_pkg::A_W'(s))
                      : (spae_pkg::HALF_TURN - spae_pkg::A_W'(s));
        end else if (x_neg) begin
            a = spae_pkg::FULL_TURN - spae_pkg::A_W'(s);
        end else begin
            a = '0;
        end
    end

    assign a_sat     = (a >= spae_pkg::FULL_TURN) ? spae_pkg::ANGLE_MAX
                                                  : a[spae_pkg::ANG_W-1:0];
    assign back_step = r_last - a_sat;
    assign hold      = (a_sat < r_last) && (spae_pkg::A_W'(back_step) < spae_pkg::HALF_TURN);

    assign load_out = (r_state == B_ANG) && (!r_out_valid || i_m_tready);
    assign o_pop    = (r_state == B_IDLE) && !i_q_stat.empty;

    assign o_m_tvalid = r_out_valid;
    assign o_angle    = spae_pkg::ANGLE_OUT_W'(r_angle);
    assign o_held     = r_held;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_stat.empty) n_state = B_SUM;
            B_SUM:   n_state = B_ASIN;
            B_ASIN:  n_state = B_ANG;
            B_ANG:   if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_older     <= '0;
            r_newer     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < spae_pkg::LINE_DEPTH; k++) begin
                r_line[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == B_SUM) begin
                r_older <= r_older + spae_pkg::SUM_W'(crossing) - spae_pkg::SUM_W'(leaving);
                r_newer <= r_newer + spae_pkg::SUM_W'(r_x) - spae_pkg::SUM_W'(crossing);
                for (int k = 0; k < spae_pkg::LINE_DEPTH - 1; k++) begin
                    r_line[k] <= r_line[k+1];
                end
                r_line[spae_pkg::LINE_DEPTH-1] <= r_x;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_last      <= hold ? r_last : a_sat;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x <= i_x;
        end
        if (r_state == B_SUM) begin
            r_base <= spae_pkg::ASIN_TAB[idx];
            r_diff <= spae_pkg::ASIN_TAB[idx_next] - spae_pkg::ASIN_TAB[idx];
            r_frac <= m[spae_pkg::FRAC_W-1:0];
        end
        if (r_state == B_ASIN) begin
            r_prod <= spae_pkg::PROD_W'(r_diff) * spae_pkg::PROD_W'(r_frac);
            r_dpos <= (d > 0);
        end
        if (load_out) begin
            r_angle <= hold ? r_last : a_sat;
            r_held  <= hold;
        end
    end

endmodule

// ----- hw/rtl/single_phase_angle_estimator_top.sv -----
// ============================================================================
// single_phase_angle_estimator_top
// Grid phase angle from one sample and the inverse RMS per beat.
// ============================================================================
// Input stream: each beat carries one signed grid sample and the inverse RMS
// (unsigned Q0.24). Output stream: one beat per input beat, the phase angle
// (65536 per turn) in tdata and the hold flag in tuser.
// Beats are paced by the four-step scaling sequence in the front section
// (accept, two registered multiply steps, round/saturate and push) and the
// matching four-step sequence of the back section (pop, window update with
// table read, interpolation multiply, quadrant and hold). Neither section
// takes a new beat before it has finished its sequence.
// A two-entry queue sits between the sections and a register holds the
// result, so a new beat is taken while a result waits on the output.
// Reset clears the delay line, the window sums, the last angle, the queue and
// all valid flags. When the receiver stalls, the result holds, the back
// section waits, the queue fills and tready falls.
// ============================================================================
module single_phase_angle_estimator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [15:0] sample, [39:16] inverse_rms
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] angle
    output logic        o_m_tuser    // [0] held
);

    spae_pkg::t_q_push               q_push;
    spae_pkg::t_q_stat               q_stat;
    logic                            q_pop;
    logic signed [spae_pkg::X_W-1:0] q_x;

    spae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_sample      ($signed(i_s_tdata[15:0])),
        .i_inverse_rms (i_s_tdata[39:16]),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push)
    );

    spae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_x     (q_x)
    );

    spae_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_x        (q_x),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_angle    (o_m_tdata),
        .o_held     (o_m_tuser)
    );

endmodule

// ----- hw/rtl/spae_checker.sv -----
// ============================================================================
// spae_checker
// Port-level checks of the angle estimator, bound to the top level.
// ============================================================================
module spae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic       in_beat;
    logic       out_beat;
    logic [3:0] r_pending;
    logic [15:0] r_prev_angle;

    assign in_beat  = i_s_tvalid && o_s_tready;
    assign out_beat = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_prev_angle <= '0;
        end else begin
            case ({in_beat, out_beat})
                2'b10:   r_pending <= r_pending + 4'd1;
                2'b01:   r_pending <= r_pending - 4'd1;
                default: r_pending <= r_pending;
            endcase
            if (out_beat) begin
                r_prev_angle <= o_m_tdata;
            end
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (r_pending != 4'd0))
        else $error("result beat without a pending input beat");

    a_held_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_m_tuser) |-> (o_m_tdata == r_prev_angle))
        else $error("held beat does not repeat the previous angle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result changed while stalled");

endmodule

bind single_phase_angle_estimator_top spae_checker u_spae_checker (.*);
